@@ rtl/core/sync_length_frame_deframer_macros.svh @@
// Assertion macros used by the deframer parser RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

`define SLFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLFD_ASSERT(label, clk, rst_n, prop, msg)

`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/slfd_pkg.sv @@
// Shared types and constants for the sync/type/length frame deframer.
// No dependencies.
package slfd_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 16;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int OUT_COUNT_W     = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [BYTE_W-1:0] SYNC_VALUE_RST = 8'd126;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 16'd4096;
    localparam logic [BYTE_W-1:0] LEN_BIAS       = 8'h20;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_VALUE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'd1;

    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_GOOD = 2'd1,
        STATUS_FAIL = 2'd2
    } status_t;

    // per-item fields that are not held in parser state
    typedef struct packed {
        status_t            status;
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
        logic [LEN_W-1:0]   payload_index;
        logic               length_rejected;
    } result_t;

    // frame completion strobes to the counters
    typedef struct packed {
        logic good;
        logic fail;
    } frame_event_t;

endpackage

@@ rtl/core/slfd_config.sv @@
// Configuration registers: sync byte and maximum payload length.
// Depends on slfd_pkg.
module slfd_config (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [slfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [slfd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output logic [slfd_pkg::BYTE_W-1:0]        sync_value,
    output logic [slfd_pkg::LEN_W-1:0]         max_length
);
    import slfd_pkg::*;

    logic [BYTE_W-1:0] sync_value_reg;
    logic [LEN_W-1:0]  max_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg <= SYNC_VALUE_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SYNC_VALUE: sync_value_reg <= cfg_wr_data[BYTE_W-1:0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign sync_value = sync_value_reg;
    assign max_length = max_length_reg;

endmodule

@@ rtl/core/slfd_parser.sv @@
// Frame parser: phase FSM, stored type/length, payload index and running XOR.
// Depends on slfd_pkg and sync_length_frame_deframer_macros.svh.
`include "sync_length_frame_deframer_macros.svh"

module slfd_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  logic [slfd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [slfd_pkg::BYTE_W-1:0]  sync_value,
    input  logic [slfd_pkg::LEN_W-1:0]   max_length,
    output slfd_pkg::result_t            result,
    output slfd_pkg::frame_event_t       frame_event,
    output logic [slfd_pkg::BYTE_W-1:0]  frame_type,
    output logic [slfd_pkg::LEN_W-1:0]   frame_length,
    output logic                         mid_frame
);
    import slfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    phase_t            phase_reg,   phase_next;
    logic [BYTE_W-1:0] type_reg,    type_next;
    logic [BYTE_W-1:0] len_lo_reg,  len_lo_next;
    logic [LEN_W-1:0]  length_reg,  length_next;
    logic [LEN_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;

    logic [BYTE_W-1:0] len_hi;
    logic [LEN_W-1:0]  len_decoded;
    logic [LEN_W-1:0]  count_inc;
    frame_event_t      event_raw;

    assign len_hi      = rx_byte - LEN_BIAS;
    assign len_decoded = {len_hi, len_lo_reg};
    assign count_inc   = count_reg + LEN_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_lo_next = len_lo_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        result      = '0;
        event_raw   = '0;
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == sync_value) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = rx_byte;
                count_next = '0;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_lo_next = rx_byte - LEN_BIAS;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = len_decoded;
                count_next  = '0;
                xor_next    = type_reg ^ len_lo_reg ^ len_hi;
                if (len_decoded > max_length) begin
                    result.length_rejected = 1'b1;
                    phase_next = PH_HUNT;
                end else if (len_decoded != '0) begin
                    phase_next = PH_PAYLOAD;
                end else begin
                    phase_next = PH_CHECK;
                end
            end
            PH_PAYLOAD: begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                xor_next   = xor_reg ^ rx_byte;
                count_next = count_inc;
                if (count_inc >= length_reg) begin
                    phase_next = PH_CHECK;
                end
            end
            default: begin
                // checksum byte closes the frame
                phase_next = PH_HUNT;
                if (rx_byte == xor_reg) begin
                    result.status  = STATUS_GOOD;
                    event_raw.good = 1'b1;
                end else begin
                    result.status  = STATUS_FAIL;
                    event_raw.fail = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            len_lo_reg <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            xor_reg    <= '0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_lo_reg <= len_lo_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
        end
    end

    assign frame_event.good = in_fire & event_raw.good;
    assign frame_event.fail = in_fire & event_raw.fail;
    assign frame_type       = type_reg;
    assign frame_length     = length_reg;
    assign mid_frame        = (phase_reg != PH_HUNT);

    `SLFD_ASSERT(a_payload_idx_in_range, aclk, aresetn, (phase_reg != PH_PAYLOAD) || (count_reg < length_reg), "payload index reached frame length")
    `SLFD_ASSERT_NEXT(a_payload_idx_step, aclk, aresetn, in_fire && (phase_reg == PH_PAYLOAD), count_reg == $past(count_reg) + LEN_W'(1), "payload index did not advance by one")
    `SLFD_ASSERT_NEXT(a_hold_when_idle, aclk, aresetn, !in_fire, $stable(phase_reg) && $stable(xor_reg), "parser state moved without an item")
    `SLFD_ASSERT_NEXT(a_reject_hunts, aclk, aresetn, in_fire && result.length_rejected, phase_reg == PH_HUNT, "rejected length did not return to hunting")

endmodule

@@ rtl/core/slfd_counters.sv @@
// Wrapping good-frame and checksum-failure counters.
// Depends on slfd_pkg.
module slfd_counters #(
    parameter int COUNT_WIDTH = slfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  slfd_pkg::frame_event_t     frame_event,
    output logic [COUNT_WIDTH-1:0]     good_count,
    output logic [COUNT_WIDTH-1:0]     fail_count
);
    import slfd_pkg::*;

    logic [COUNT_WIDTH-1:0] good_reg;
    logic [COUNT_WIDTH-1:0] fail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg <= '0;
            fail_reg <= '0;
        end else begin
            if (frame_event.good) begin
                good_reg <= good_reg + COUNT_WIDTH'(1);
            end
            if (frame_event.fail) begin
                fail_reg <= fail_reg + COUNT_WIDTH'(1);
            end
        end
    end

    assign good_count = good_reg;
    assign fail_count = fail_reg;

endmodule

@@ rtl/core/sync_length_frame_deframer.sv @@
// Byte-stream deframer: hunts for a sync byte, reads type and biased
// little-endian length, streams the payload and checks an XOR checksum.
//
// Usage:
//   s_valid/s_ready carry one received byte per item on s_rx_byte.
//   m_valid/m_ready carry one result item for every accepted byte.
//   cfg_wr_en/cfg_index/cfg_wr_data write sync_value (index 0) and
//   max_length (index 1); write only while no item is in flight.
//   The result of a byte accepted at an edge is registered and valid after
//   that edge. Throughput is one byte per cycle while the receiver does not
//   stall, set by the single parser stage feeding one output register.
//   When the receiver stalls, the held result stays on m_* and s_ready
//   drops until it is taken; the next byte is taken in the same cycle the
//   held result leaves.
//   Synchronous active-low reset returns to hunting, clears stored type,
//   length and counters, and restores sync_value 126 and max_length 4096.
//   Counters are COUNT_WIDTH wide and wrap; the ports show the low 32 bits.
// Depends on slfd_pkg, slfd_config, slfd_parser, slfd_counters.
module sync_length_frame_deframer #(
    parameter int COUNT_WIDTH = slfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [slfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slfd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [slfd_pkg::BYTE_W-1:0]       s_rx_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [slfd_pkg::BYTE_W-1:0]       m_frame_type,
    output logic                              m_payload_valid,
    output logic [slfd_pkg::BYTE_W-1:0]       m_payload_byte,
    output logic [slfd_pkg::LEN_W-1:0]        m_payload_index,
    output logic [slfd_pkg::LEN_W-1:0]        m_frame_length,
    output logic                              m_length_rejected,
    output logic                              m_mid_frame,
    output logic [slfd_pkg::OUT_COUNT_W-1:0]  m_good_frames,
    output logic [slfd_pkg::OUT_COUNT_W-1:0]  m_checksum_failures
);
    import slfd_pkg::*;

    logic                   in_fire;
    logic [BYTE_W-1:0]      sync_value;
    logic [LEN_W-1:0]       max_length;
    result_t                result_next;
    result_t                result_reg;
    frame_event_t           frame_event;
    logic                   m_valid_reg;
    logic [COUNT_WIDTH-1:0] good_count;
    logic [COUNT_WIDTH-1:0] fail_count;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    slfd_config u_config (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sync_value  (sync_value),
        .max_length  (max_length)
    );

    // type, length, phase and counters are state that only moves on an
    // accepted byte, so they already read as the held item's values
    slfd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .rx_byte      (s_rx_byte),
        .sync_value   (sync_value),
        .max_length   (max_length),
        .result       (result_next),
        .frame_event  (frame_event),
        .frame_type   (m_frame_type),
        .frame_length (m_frame_length),
        .mid_frame    (m_mid_frame)
    );

    slfd_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_event (frame_event),
        .good_count  (good_count),
        .fail_count  (fail_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = result_reg.status;
    assign m_payload_valid     = result_reg.payload_valid;
    assign m_payload_byte      = result_reg.payload_byte;
    assign m_payload_index     = result_reg.payload_index;
    assign m_length_rejected   = result_reg.length_rejected;
    assign m_good_frames       = OUT_COUNT_W'(good_count);
    assign m_checksum_failures = OUT_COUNT_W'(fail_count);

endmodule
